/* sv/assert_macros.svh */
// Assertion macros shared by the hub label distance query RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/hld_pkg.sv */
// Shared constants and entry types for the hub label distance query unit.
package hld_pkg;

	localparam int NODE_COUNT  = 65536;
	localparam int LABEL_DEPTH = 1048576;
	localparam int NO_PATH     = 10000;

	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int ADDR_W = $clog2(LABEL_DEPTH);
	localparam int CNT_W  = ADDR_W + 1;
	localparam int RANK_W = 16;
	localparam int DIST_W = 14;
	localparam int OFF_W  = 20;

	typedef enum logic [1:0] {
		OP_NODE      = 2'd0,
		OP_IN_LABEL  = 2'd1,
		OP_OUT_LABEL = 2'd2,
		OP_QUERY     = 2'd3
	} op_t;

	typedef struct packed {
		logic              last;
		logic [DIST_W-1:0] hdist;
		logic [RANK_W-1:0] hub;
	} label_t;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [OFF_W-1:0]  in_off;
		logic [OFF_W-1:0]  out_off;
	} node_t;

endpackage

/* sv/hld_node_mem.sv */
// Node table memory: one write port, two registered read ports.
module hld_node_mem (
	input  logic                      clk,
	input  logic                      we,
	input  logic [hld_pkg::NODE_W-1:0] waddr,
	input  hld_pkg::node_t            wdata,
	input  logic                      re,
	input  logic [hld_pkg::NODE_W-1:0] raddr_a,
	input  logic [hld_pkg::NODE_W-1:0] raddr_b,
	output hld_pkg::node_t            rdata_a,
	output hld_pkg::node_t            rdata_b
);

	hld_pkg::node_t mem [hld_pkg::NODE_COUNT];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

/* sv/hld_label_mem.sv */
// Label store memory: one write port, one registered read port that holds its data.
module hld_label_mem (
	input  logic                      clk,
	input  logic                      we,
	input  logic [hld_pkg::ADDR_W-1:0] waddr,
	input  hld_pkg::label_t           wdata,
	input  logic                      re,
	input  logic [hld_pkg::ADDR_W-1:0] raddr,
	output hld_pkg::label_t           rdata
);

	hld_pkg::label_t mem [hld_pkg::LABEL_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/hub_label_distance_query_unit.sv */
// Hub label distance query unit: node table, two label stores and the query sequencer.
//
// Write requests (opcode 0, 1, 2) leave the sequencer in idle. A query request with equal
// source and target goes straight to the output state. Any other query passes the node
// table read, then the merge steps (each step advances the walked list, the other list,
// or both), the remaining scan steps on the walked list, and the load of the result.
// Each step waits on the registered read data of the two label store memories, which
// are read in parallel.
// The next request is accepted when the sequencer is back in idle; a finished result may
// still wait in the output register meanwhile.
`include "assert_macros.svh"

module hub_label_distance_query_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [15:0] node_a,
	input  logic [15:0] node_b,
	input  logic [15:0] node_rank,
	input  logic [19:0] in_offset,
	input  logic [19:0] out_offset,
	input  logic [19:0] label_addr,
	input  logic [15:0] hub_rank,
	input  logic [13:0] hub_dist,
	input  logic        label_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [13:0] distance
);

	localparam int ADDR_W = hld_pkg::ADDR_W;
	localparam int CNT_W  = hld_pkg::CNT_W;
	localparam int DIST_W = hld_pkg::DIST_W;
	localparam int RANK_W = hld_pkg::RANK_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_NODE  = 5'b00010,
		ST_MERGE = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic              sel_q, sel_d;
	logic [RANK_W-1:0] small_q, small_d;
	logic [DIST_W-1:0] ans_q, ans_d;
	logic [ADDR_W-1:0] iaddr_q, oaddr_q;
	logic [CNT_W-1:0]  icnt_q, ocnt_q;
	logic              out_valid_q;
	logic [DIST_W-1:0] dist_q;

	logic              accept;
	hld_pkg::op_t      op;
	logic              node_we, node_re, in_we, out_we;
	logic              start_walk, adv_x, adv_y, adv_in, adv_out;
	logic              in_re, out_re;
	logic [ADDR_W-1:0] in_raddr, out_raddr;
	hld_pkg::node_t    node_wdata, na_rd, nb_rd;
	hld_pkg::label_t   lbl_wdata, in_rd, out_rd, x_ent, y_ent;
	logic              in_end, out_end, x_end, y_end;
	logic [DIST_W:0]   sum;
	logic              stall_out, same_query, walk_busy;

	assign accept     = in_valid && in_ready;
	assign op         = hld_pkg::op_t'(opcode);
	assign in_ready   = (state_q == ST_IDLE);
	assign node_we    = accept && (op == hld_pkg::OP_NODE);
	assign in_we      = accept && (op == hld_pkg::OP_IN_LABEL);
	assign out_we     = accept && (op == hld_pkg::OP_OUT_LABEL);
	assign node_re    = accept && (op == hld_pkg::OP_QUERY);
	assign node_wdata = '{rank: node_rank, in_off: in_offset, out_off: out_offset};
	assign lbl_wdata  = '{last: label_end, hdist: hub_dist, hub: hub_rank};

	hld_node_mem u_node (
		.clk     (clk),
		.we      (node_we),
		.waddr   (hld_pkg::NODE_W'(node_a)),
		.wdata   (node_wdata),
		.re      (node_re),
		.raddr_a (hld_pkg::NODE_W'(node_a)),
		.raddr_b (hld_pkg::NODE_W'(node_b)),
		.rdata_a (na_rd),
		.rdata_b (nb_rd)
	);

	hld_label_mem u_in_lbl (
		.clk   (clk),
		.we    (in_we),
		.waddr (ADDR_W'(label_addr)),
		.wdata (lbl_wdata),
		.re    (in_re),
		.raddr (in_raddr),
		.rdata (in_rd)
	);

	hld_label_mem u_out_lbl (
		.clk   (clk),
		.we    (out_we),
		.waddr (ADDR_W'(label_addr)),
		.wdata (lbl_wdata),
		.re    (out_re),
		.raddr (out_raddr),
		.rdata (out_rd)
	);

	assign in_end  = in_rd.last || icnt_q[CNT_W-1];
	assign out_end = out_rd.last || ocnt_q[CNT_W-1];
	assign x_ent   = sel_q ? out_rd : in_rd;
	assign y_ent   = sel_q ? in_rd : out_rd;
	assign x_end   = sel_q ? out_end : in_end;
	assign y_end   = sel_q ? in_end : out_end;
	assign sum     = {1'b0, x_ent.hdist} + {1'b0, y_ent.hdist};

	assign adv_in    = sel_q ? adv_y : adv_x;
	assign adv_out   = sel_q ? adv_x : adv_y;
	assign in_re     = start_walk || adv_in;
	assign out_re    = start_walk || adv_out;
	assign in_raddr  = start_walk ? ADDR_W'(nb_rd.in_off) : iaddr_q + ADDR_W'(1);
	assign out_raddr = start_walk ? ADDR_W'(na_rd.out_off) : oaddr_q + ADDR_W'(1);

	always_comb begin
		state_d    = state_q;
		sel_d      = sel_q;
		small_d    = small_q;
		ans_d      = ans_q;
		start_walk = 1'b0;
		adv_x      = 1'b0;
		adv_y      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (op == hld_pkg::OP_QUERY)) begin
					ans_d = DIST_W'(hld_pkg::NO_PATH);
					if (node_a == node_b) begin
						ans_d   = '0;
						state_d = ST_OUT;
					end else begin
						state_d = ST_NODE;
					end
				end
			end
			ST_NODE: begin
				start_walk = 1'b1;
				sel_d      = (na_rd.rank > nb_rd.rank);
				small_d    = sel_d ? nb_rd.rank : na_rd.rank;
				state_d    = ST_MERGE;
			end
			ST_MERGE: begin
				priority if (x_end || y_end || (x_ent.hub >= small_q)) begin
					state_d = ST_SCAN;
				end else if (x_ent.hub == y_ent.hub) begin
					adv_x = 1'b1;
					adv_y = 1'b1;
					if (sum < {1'b0, ans_q}) begin
						ans_d = sum[DIST_W-1:0];
					end
				end else if (x_ent.hub < y_ent.hub) begin
					adv_x = 1'b1;
				end else begin
					adv_y = 1'b1;
				end
			end
			ST_SCAN: begin
				priority if (x_end) begin
					state_d = ST_OUT;
				end else if (x_ent.hub < small_q) begin
					adv_x = 1'b1;
				end else begin
					if ((x_ent.hub == small_q) && (x_ent.hdist < ans_q)) begin
						ans_d = x_ent.hdist;
					end
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_OUT) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		sel_q   <= sel_d;
		small_q <= small_d;
		ans_q   <= ans_d;
		if ((state_q == ST_OUT) && (!out_valid_q || out_ready)) begin
			dist_q <= ans_q;
		end
		if (start_walk) begin
			iaddr_q <= in_raddr;
			oaddr_q <= out_raddr;
			icnt_q  <= '0;
			ocnt_q  <= '0;
		end else begin
			if (adv_in) begin
				iaddr_q <= in_raddr;
				icnt_q  <= icnt_q + CNT_W'(1);
			end
			if (adv_out) begin
				oaddr_q <= out_raddr;
				ocnt_q  <= ocnt_q + CNT_W'(1);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = dist_q;

	assign stall_out  = (state_q == ST_OUT) && out_valid_q && !out_ready;
	assign same_query = accept && (op == hld_pkg::OP_QUERY) && (node_a == node_b);
	assign walk_busy  = (state_q == ST_MERGE) || (state_q == ST_SCAN) || (state_q == ST_OUT);

	`ASSERT_NXT(a_result_held, clk, arst_n, stall_out, state_q == ST_OUT)
	`ASSERT_NXT(a_same_node, clk, arst_n, same_query, (state_q == ST_OUT) && (ans_q == '0))
	`ASSERT_IMP(a_ans_bound, clk, arst_n, walk_busy, ans_q <= DIST_W'(hld_pkg::NO_PATH))
	`ASSERT_NXT(a_scan_exit, clk, arst_n, state_q == ST_SCAN, state_q inside {ST_SCAN, ST_OUT})

endmodule
